// File: design/vrip_pkg.sv
package vrip_pkg;

  typedef enum logic [2:0] {
    REG_SIN_X    = 3'd0,
    REG_COS_X    = 3'd1,
    REG_SIN_Y    = 3'd2,
    REG_COS_Y    = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic signed [7:0]  SIN_X_RESET    = 8'sd0;
  localparam logic signed [7:0]  COS_X_RESET    = 8'sd64;
  localparam logic signed [7:0]  SIN_Y_RESET    = 8'sd0;
  localparam logic signed [7:0]  COS_Y_RESET    = 8'sd64;
  localparam logic signed [9:0]  OFFSET_X_RESET = 10'sd0;
  localparam logic signed [7:0]  OFFSET_Y_RESET = 8'sd0;

  localparam logic signed [15:0] BALL_X_BASE   = 16'sd272;
  localparam logic signed [15:0] BALL_Y_BASE   = 16'sd224;
  localparam logic signed [15:0] SHADOW_X_BASE = 16'sd320;
  localparam logic signed [15:0] SHADOW_Y_BASE = 16'sd320;
  localparam logic signed [15:0] DEPTH_BIAS    = 16'sd96;
  localparam logic [3:0]         DEPTH_MAX     = 4'd8;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
    logic               last_ball;
  } vert_in_t;

  typedef struct packed {
    logic signed [15:0] ball_x;
    logic signed [15:0] ball_y;
    logic signed [15:0] shadow_x;
    logic signed [15:0] shadow_y;
    logic [3:0]         depth_level;
    logic               last_out;
  } ball_out_t;

  // rotation coefficients and offsets at 16 bits: registers sign-extended, cross products wrapped
  typedef struct packed {
    logic signed [15:0] sin_x;
    logic signed [15:0] cos_x;
    logic signed [15:0] sin_y;
    logic signed [15:0] cos_y;
    logic signed [15:0] cs;
    logic signed [15:0] ss;
    logic signed [15:0] cc;
    logic signed [15:0] sc;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
  } coef_t;

  // fixed point product with 6 fraction bits, wrapped to 16 bits
  function automatic logic signed [15:0] frac_mul(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic signed [31:0] prod;
    prod = a * b;
    return prod[21:6];
  endfunction

endpackage

// File: design/vertex_rotate_iso_project.sv
// Vertex rotate and isometric projection.
// Input words (in_valid/in_ready/in_data) carry one vertex each: x, y, z in
// signed fixed point with 6 fraction bits and a last-vertex flag. Each word
// gives exactly one output word (out_valid/out_ready/out_data): ball and
// shadow screen positions, a depth level 0..8 and the copied flag.
// Throughput is one word per cycle while out_ready is high. The path has
// five register stages (input, products, sums, projection, output), which
// a word passes through in that order; the eight 16x16 products of
// the products stage set the cycle time.
// The user writes coefficients through cfg_we/cfg_index/cfg_wdata only
// while the block is empty, which it does not enforce; the cross products
// settle the cycle after a write, and a word may follow from the next edge.
// Reset clears all stage valids and loads the identity rotation with zero
// offsets. When out_ready is low the output holds; the stages behind it
// keep filling bubbles and in_ready falls only once every stage is full.
module vertex_rotate_iso_project (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vrip_pkg::vert_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vrip_pkg::ball_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [vrip_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vrip_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  vrip_pkg::coef_t coef;

  vrip_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // stage enables, chained back from the output register
  logic en_out, en4, en3, en2, en1;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;

  assign en_out   = !out_valid_r || out_ready;
  assign en4      = !s4_v_r || en_out;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    s1_v_r      <= in_valid;
      if (en2)    s2_v_r      <= s1_v_r;
      if (en3)    s3_v_r      <= s2_v_r;
      if (en4)    s4_v_r      <= s3_v_r;
      if (en_out) out_valid_r <= s4_v_r;
    end
  end

  // stage 1: input word
  vrip_pkg::vert_in_t s1_r;

  always_ff @(posedge clk) begin
    if (en1) s1_r <= in_data;
  end

  // stage 2: rotation products
  logic signed [15:0] xs_r, yc_r, xcs_r, yss_r, zcy_r, xcc_r, ysc_r, zsy_r;
  logic signed [15:0] xs_nxt, yc_nxt, xcs_nxt, yss_nxt, zcy_nxt, xcc_nxt, ysc_nxt, zsy_nxt;
  logic               last2_r;

  always_comb begin
    xs_nxt  = vrip_pkg::frac_mul(s1_r.vert_x, coef.sin_x);
    yc_nxt  = vrip_pkg::frac_mul(s1_r.vert_y, coef.cos_x);
    xcs_nxt = vrip_pkg::frac_mul(s1_r.vert_x, coef.cs);
    yss_nxt = vrip_pkg::frac_mul(s1_r.vert_y, coef.ss);
    zcy_nxt = vrip_pkg::frac_mul(s1_r.vert_z, coef.cos_y);
    xcc_nxt = vrip_pkg::frac_mul(s1_r.vert_x, coef.cc);
    ysc_nxt = vrip_pkg::frac_mul(s1_r.vert_y, coef.sc);
    zsy_nxt = vrip_pkg::frac_mul(s1_r.vert_z, coef.sin_y);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      xs_r    <= xs_nxt;
      yc_r    <= yc_nxt;
      xcs_r   <= xcs_nxt;
      yss_r   <= yss_nxt;
      zcy_r   <= zcy_nxt;
      xcc_r   <= xcc_nxt;
      ysc_r   <= ysc_nxt;
      zsy_r   <= zsy_nxt;
      last2_r <= s1_r.last_ball;
    end
  end

  // stage 3: rotated coordinates plus offsets, all mod 2^16
  logic signed [15:0] tx_r, ty_r, tz_r, tx_nxt, ty_nxt, tz_nxt;
  logic               last3_r;

  always_comb begin
    tx_nxt = xs_r + yc_r + coef.off_x;
    ty_nxt = xcs_r - (yss_r + zcy_r) + coef.off_y;
    tz_nxt = xcc_r - (ysc_r - zsy_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
      tz_r    <= tz_nxt;
      last3_r <= last2_r;
    end
  end

  // stage 4: isometric projection and depth bucket
  logic signed [15:0] xsum, dsum, px_r, py_r, px_nxt, py_nxt;
  logic [3:0]         depth_r, depth_nxt;
  logic               last4_r;

  always_comb begin
    xsum   = tx_r + (tz_r >>> 3);
    px_nxt = xsum >>> 3;
    py_nxt = ty_r >>> 3;
    dsum   = tz_r + vrip_pkg::DEPTH_BIAS;
    // negative depth sums clamp to the nearest bucket
    if (dsum[15]) begin
      depth_nxt = 4'd0;
    end else if (dsum[14:6] > 9'(vrip_pkg::DEPTH_MAX)) begin
      depth_nxt = vrip_pkg::DEPTH_MAX;
    end else begin
      depth_nxt = dsum[9:6];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      depth_r <= depth_nxt;
      last4_r <= last3_r;
    end
  end

  // stage 5: screen placement into the output register
  vrip_pkg::ball_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.ball_x      = vrip_pkg::BALL_X_BASE + px_r;
    out_nxt.ball_y      = vrip_pkg::BALL_Y_BASE + py_r;
    out_nxt.shadow_x    = vrip_pkg::SHADOW_X_BASE + px_r;
    out_nxt.shadow_y    = vrip_pkg::SHADOW_Y_BASE + (py_r >>> 2);
    out_nxt.depth_level = depth_r;
    out_nxt.last_out    = last4_r;
  end

  always_ff @(posedge clk) begin
    if (en_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // an empty output stage means every stage behind it can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low while output stage is empty");

  // a word in the projection stage survives an output stall
  a_stall_keeps_s4: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && out_valid_r && !out_ready) |=> s4_v_r)
    else $error("projection stage word dropped during stall");

  // the depth bucket never exceeds its clamp
  a_depth_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.depth_level <= vrip_pkg::DEPTH_MAX))
    else $error("depth level above clamp");
`endif

endmodule

// File: design/vrip_coef.sv
module vrip_coef (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vrip_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vrip_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output vrip_pkg::coef_t                     coef
);

  logic signed [7:0]  sin_x_r, cos_x_r, sin_y_r, cos_y_r, offset_y_r;
  logic signed [9:0]  offset_x_r;
  logic signed [15:0] sin_x_ext, cos_x_ext, sin_y_ext, cos_y_ext;
  logic signed [15:0] cs_r, ss_r, cc_r, sc_r;
  logic signed [15:0] cs_nxt, ss_nxt, cc_nxt, sc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_x_r    <= vrip_pkg::SIN_X_RESET;
      cos_x_r    <= vrip_pkg::COS_X_RESET;
      sin_y_r    <= vrip_pkg::SIN_Y_RESET;
      cos_y_r    <= vrip_pkg::COS_Y_RESET;
      offset_x_r <= vrip_pkg::OFFSET_X_RESET;
      offset_y_r <= vrip_pkg::OFFSET_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vrip_pkg::REG_SIN_X:    sin_x_r    <= cfg_wdata[7:0];
        vrip_pkg::REG_COS_X:    cos_x_r    <= cfg_wdata[7:0];
        vrip_pkg::REG_SIN_Y:    sin_y_r    <= cfg_wdata[7:0];
        vrip_pkg::REG_COS_Y:    cos_y_r    <= cfg_wdata[7:0];
        vrip_pkg::REG_OFFSET_X: offset_x_r <= cfg_wdata;
        vrip_pkg::REG_OFFSET_Y: offset_y_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign sin_x_ext = {{8{sin_x_r[7]}}, sin_x_r};
  assign cos_x_ext = {{8{cos_x_r[7]}}, cos_x_r};
  assign sin_y_ext = {{8{sin_y_r[7]}}, sin_y_r};
  assign cos_y_ext = {{8{cos_y_r[7]}}, cos_y_r};

  always_comb begin
    cs_nxt = vrip_pkg::frac_mul(cos_x_ext, sin_y_ext);
    ss_nxt = vrip_pkg::frac_mul(sin_y_ext, sin_x_ext);
    cc_nxt = vrip_pkg::frac_mul(cos_x_ext, cos_y_ext);
    sc_nxt = vrip_pkg::frac_mul(sin_x_ext, cos_y_ext);
  end

  // cross products follow the coefficient registers in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= 16'sd0;
      ss_r <= 16'sd0;
      cc_r <= 16'sd64;
      sc_r <= 16'sd0;
    end else begin
      cs_r <= cs_nxt;
      ss_r <= ss_nxt;
      cc_r <= cc_nxt;
      sc_r <= sc_nxt;
    end
  end

  always_comb begin
    coef.sin_x = sin_x_ext;
    coef.cos_x = cos_x_ext;
    coef.sin_y = sin_y_ext;
    coef.cos_y = cos_y_ext;
    coef.cs    = cs_r;
    coef.ss    = ss_r;
    coef.cc    = cc_r;
    coef.sc    = sc_r;
    coef.off_x = {{6{offset_x_r[9]}}, offset_x_r};
    coef.off_y = {{8{offset_y_r[7]}}, offset_y_r};
  end

endmodule
